### hw/rtl/mbsp_pkg.sv
// Package: shared types and constants for the MIDI byte stream parser.
package mbsp_pkg;

  // Clock pulses per beat; the pulse index wraps after this many clocks
  localparam int unsigned PulsesPerBeat = 24;
  localparam int unsigned PulseW        = 5;

  // Depth of the queue between decode and event output
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Real-time and system bytes
  localparam logic [7:0] ByteClock    = 8'hF8;
  localparam logic [7:0] ByteStart    = 8'hFA;
  localparam logic [7:0] ByteStop     = 8'hFC;
  localparam logic [7:0] ByteSysExBeg = 8'hF0;
  localparam logic [7:0] ByteSysExEnd = 8'hF7;

  // Status high nibbles
  localparam logic [3:0] NibNoteOff  = 4'h8;
  localparam logic [3:0] NibNoteOn   = 4'h9;
  localparam logic [3:0] NibPolyAt   = 4'hA;
  localparam logic [3:0] NibCtrl     = 4'hB;
  localparam logic [3:0] NibProgram  = 4'hC;
  localparam logic [3:0] NibChanPres = 4'hD;
  localparam logic [3:0] NibSystem   = 4'hF;

  // Parse phase codes
  localparam logic [1:0] PhaseIdle  = 2'd0;
  localparam logic [1:0] PhaseData1 = 2'd1;
  localparam logic [1:0] PhaseData2 = 2'd2;

  typedef enum logic [2:0] {
    EvNoteOff  = 3'd0,
    EvNoteOn   = 3'd1,
    EvPolyAt   = 3'd2,
    EvCtrl     = 3'd3,
    EvProgram  = 3'd4,
    EvStart    = 3'd5,
    EvStop     = 3'd6,
    EvClock    = 3'd7
  } event_kind_e;

  // One decoded event as it travels through the queue
  typedef struct packed {
    event_kind_e kind;
    logic [3:0]  channel;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
  } cmd_t;

endpackage

### hw/rtl/mbsp_front.sv
// Front end: accepts bytes, tracks running status and decodes events.
module mbsp_front import mbsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [7:0]        status_q, status_d;
  logic [1:0]        phase_q, phase_d;
  logic [6:0]        held_q, held_d;
  logic              excl_q, excl_d;
  logic [PulseW-1:0] pulse_q, pulse_d;
  logic              has_event;
  logic [3:0]        hi_nib;
  logic [PulseW-1:0] pulse_next;

  assign hi_nib = status_q[7:4];

  // Wrap the pulse index at the end of a beat
  assign pulse_next = (pulse_q == PulseW'(PulsesPerBeat - 1)) ? '0 : pulse_q + 1'b1;

  // Decode one byte into state updates and at most one queue entry
  always_comb begin
    status_d  = status_q;
    phase_d   = phase_q;
    held_d    = held_q;
    excl_d    = excl_q;
    pulse_d   = pulse_q;
    has_event = 1'b0;
    cmd_o.kind        = EvClock;
    cmd_o.channel     = status_q[3:0];
    cmd_o.first_data  = held_q;
    cmd_o.second_data = rx_byte_i[6:0];

    if (rx_byte_i[7:3] == 5'b11111) begin
      // Real-time bytes never touch running status
      cmd_o.channel     = '0;
      cmd_o.second_data = '0;
      cmd_o.first_data  = '0;
      unique case (rx_byte_i)
        ByteClock: begin
          pulse_d          = pulse_next;
          has_event        = 1'b1;
          cmd_o.kind       = EvClock;
          cmd_o.first_data = 7'(pulse_next);
        end
        ByteStart: begin
          pulse_d    = '0;
          has_event  = 1'b1;
          cmd_o.kind = EvStart;
        end
        ByteStop: begin
          has_event  = 1'b1;
          cmd_o.kind = EvStop;
        end
        default: ;
      endcase
    end else if (rx_byte_i == ByteSysExBeg) begin
      excl_d = 1'b1;
    end else if (rx_byte_i == ByteSysExEnd) begin
      excl_d   = 1'b0;
      status_d = '0;
      phase_d  = PhaseIdle;
    end else if (excl_q) begin
      // Drop bytes inside system exclusive
    end else if (rx_byte_i[7:4] == NibSystem) begin
      status_d = '0;
      phase_d  = PhaseIdle;
    end else if (rx_byte_i[7]) begin
      status_d = rx_byte_i;
      phase_d  = PhaseData1;
    end else if (phase_q == PhaseIdle) begin
      // Drop data without a status
    end else if (phase_q != PhaseData2) begin
      held_d = rx_byte_i[6:0];
      if (hi_nib == NibProgram) begin
        phase_d           = PhaseData1;
        has_event         = 1'b1;
        cmd_o.kind        = EvProgram;
        cmd_o.first_data  = rx_byte_i[6:0];
        cmd_o.second_data = '0;
      end else if (hi_nib == NibChanPres) begin
        phase_d = PhaseData1;
      end else begin
        phase_d = PhaseData2;
      end
    end else begin
      phase_d = PhaseData1;
      case (hi_nib)
        NibNoteOn: begin
          has_event  = 1'b1;
          cmd_o.kind = (rx_byte_i[6:0] == 7'd0) ? EvNoteOff : EvNoteOn;
        end
        NibNoteOff: begin
          has_event  = 1'b1;
          cmd_o.kind = EvNoteOff;
        end
        NibPolyAt: begin
          has_event  = 1'b1;
          cmd_o.kind = EvPolyAt;
        end
        NibCtrl: begin
          has_event  = 1'b1;
          cmd_o.kind = EvCtrl;
        end
        default: ;
      endcase
    end
  end

  assign push_o = accept_i && has_event;

  // Advance parser state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= '0;
      phase_q  <= PhaseIdle;
      held_q   <= '0;
      excl_q   <= 1'b0;
      pulse_q  <= '0;
    end else if (accept_i) begin
      status_q <= status_d;
      phase_q  <= phase_d;
      held_q   <= held_d;
      excl_q   <= excl_d;
      pulse_q  <= pulse_d;
    end
  end

endmodule

### hw/rtl/mbsp_queue.sv
// Queue: short FIFO of decoded events between front end and output stage.
module mbsp_queue import mbsp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_data_o
);

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;

  assign full_o     = (count_q == QueueCntW'(QueueDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/mbsp_back.sv
// Back end: output register that delivers events, expanding start into start plus clock 0.
module mbsp_back import mbsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cmd_t       q_data_i,
  output logic       q_pop_o,
  output logic       ev_valid_o,
  input  logic       ev_ready_i,
  output logic [2:0] event_kind_o,
  output logic [3:0] channel_o,
  output logic [6:0] first_data_o,
  output logic [6:0] second_data_o,
  output logic       last_of_run_o
);

  logic valid_q;
  logic follow_q;
  cmd_t out_q;
  logic last_q;
  logic out_free;

  assign out_free = !valid_q || ev_ready_i;
  assign q_pop_o  = out_free && !follow_q && q_valid_i;

  // Track output valid and the pending clock 0 after start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      follow_q <= 1'b0;
    end else if (out_free) begin
      if (follow_q) begin
        valid_q  <= 1'b1;
        follow_q <= 1'b0;
      end else begin
        valid_q  <= q_valid_i;
        follow_q <= q_valid_i && (q_data_i.kind == EvStart);
      end
    end
  end

  // Load the output payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (follow_q) begin
        out_q.kind        <= EvClock;
        out_q.channel     <= '0;
        out_q.first_data  <= '0;
        out_q.second_data <= '0;
        last_q            <= 1'b1;
      end else if (q_valid_i) begin
        out_q  <= q_data_i;
        last_q <= (q_data_i.kind != EvStart);
      end
    end
  end

  assign ev_valid_o    = valid_q;
  assign event_kind_o  = out_q.kind;
  assign channel_o     = out_q.channel;
  assign first_data_o  = out_q.first_data;
  assign second_data_o = out_q.second_data;
  assign last_of_run_o = last_q;

endmodule

### hw/rtl/midi_byte_stream_parser.sv
// Top level: MIDI byte stream parser with running status.
//
// One MIDI byte is accepted per cycle while the queue is not full and is
// decoded in that cycle. The events it causes go into a four-entry queue
// and leave through a registered output beat. Bytes that cause no event
// never occupy the queue. Single-event bytes sustain one byte per cycle
// while ev_ready stays high. A start byte yields two output beats (start,
// then clock 0 with last_of_run set), so a run of start bytes is slowed by
// the single output register, which gives both beats before it takes the
// next queue entry. Input ready drops only while the queue is full.
// Real-time bytes F8..FF are acted on anywhere, including inside system
// exclusive, and leave running status untouched.
module midi_byte_stream_parser import mbsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       ev_valid_o,
  input  logic       ev_ready_i,
  output logic [2:0] event_kind_o,
  output logic [3:0] channel_o,
  output logic [6:0] first_data_o,
  output logic [6:0] second_data_o,
  output logic       last_of_run_o
);

  logic accept;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  assign rx_ready_o = !q_full;
  assign accept     = rx_valid_i && rx_ready_o;

  // Decode bytes
  mbsp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  // Buffer decoded events
  mbsp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_cmd)
  );

  // Deliver event beats
  mbsp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_data_i      (q_cmd),
    .q_pop_o       (q_pop),
    .ev_valid_o    (ev_valid_o),
    .ev_ready_i    (ev_ready_i),
    .event_kind_o  (event_kind_o),
    .channel_o     (channel_o),
    .first_data_o  (first_data_o),
    .second_data_o (second_data_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

### dv/mbsp_event_checker.sv
// Checker: watches both channels of the MIDI parser, predicts events and compares them.
module mbsp_event_checker import mbsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  input  logic        rx_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        ev_valid_i,
  input  logic        ev_ready_i,
  input  logic [2:0]  event_kind_i,
  input  logic [3:0]  channel_i,
  input  logic [6:0]  first_data_i,
  input  logic [6:0]  second_data_i,
  input  logic        last_of_run_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_events_o
);

  typedef struct packed {
    event_kind_e kind;
    logic [3:0]  channel;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic        last;
  } midi_event_t;

  // Predicted parser state
  logic [7:0]        run_status;
  logic [1:0]        phase;
  logic [6:0]        held_data;
  logic              excl_open;
  logic [PulseW-1:0] pulse_idx;

  midi_event_t wanted_events[$];
  midi_event_t want, got;

  function automatic void queue_event(event_kind_e kind, logic [3:0] chan,
                                      logic [6:0] d1, logic [6:0] d2, logic last);
    midi_event_t ev;
    ev.kind        = kind;
    ev.channel     = chan;
    ev.first_data  = d1;
    ev.second_data = d2;
    ev.last        = last;
    wanted_events.push_back(ev);
  endfunction

  // Advance the predicted parser by one byte and queue the events it causes
  function automatic void decode_midi_byte(logic [7:0] b);
    logic [3:0] nib;
    logic [3:0] chan;
    int         next_pulse;
    nib  = run_status[7:4];
    chan = run_status[3:0];
    if (b >= ByteClock) begin
      // real-time bytes: never touch running status
      if (b == ByteClock) begin
        next_pulse = int'(pulse_idx) + 1;
        if (next_pulse > int'(PulsesPerBeat) - 1) next_pulse = 0;
        pulse_idx = PulseW'(next_pulse);
        queue_event(EvClock, 4'd0, 7'(pulse_idx), 7'd0, 1'b1);
      end else if (b == ByteStart) begin
        pulse_idx = '0;
        queue_event(EvStart, 4'd0, 7'd0, 7'd0, 1'b0);
        queue_event(EvClock, 4'd0, 7'd0, 7'd0, 1'b1);
      end else if (b == ByteStop) begin
        queue_event(EvStop, 4'd0, 7'd0, 7'd0, 1'b1);
      end
    end else if (b == ByteSysExBeg) begin
      excl_open = 1'b1;
    end else if (b == ByteSysExEnd) begin
      excl_open  = 1'b0;
      run_status = '0;
      phase      = PhaseIdle;
    end else if (excl_open) begin
      // drop everything inside exclusive
    end else if (b[7:4] == NibSystem) begin
      run_status = '0;
      phase      = PhaseIdle;
    end else if (b[7]) begin
      run_status = b;
      phase      = PhaseData1;
    end else if (phase == PhaseIdle) begin
      // data byte with no status in force
    end else if (phase != PhaseData2) begin
      held_data = b[6:0];
      if (nib == NibProgram) begin
        phase = PhaseData1;
        queue_event(EvProgram, chan, b[6:0], 7'd0, 1'b1);
      end else if (nib == NibChanPres) begin
        phase = PhaseData1;
      end else begin
        phase = PhaseData2;
      end
    end else begin
      phase = PhaseData1;
      case (nib)
        NibNoteOn: begin
          queue_event((b[6:0] == 7'd0) ? EvNoteOff : EvNoteOn, chan, held_data, b[6:0],
                      1'b1);
        end
        NibNoteOff: queue_event(EvNoteOff, chan, held_data, b[6:0], 1'b1);
        NibPolyAt:  queue_event(EvPolyAt, chan, held_data, b[6:0], 1'b1);
        NibCtrl:    queue_event(EvCtrl, chan, held_data, b[6:0], 1'b1);
        default: ;
      endcase
    end
  endfunction

  // Compare the output beat first, then fold in the input beat of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_status = '0;
      phase      = PhaseIdle;
      held_data  = '0;
      excl_open  = 1'b0;
      pulse_idx  = '0;
      wanted_events.delete();
      mismatch_count_o = 0;
    end else begin
      if (ev_valid_i && ev_ready_i) begin
        got = {event_kind_e'(event_kind_i), channel_i, first_data_i, second_data_i,
               last_of_run_i};
        if (wanted_events.size() == 0) begin
          $display("%0t: unexpected event kind=%0d ch=%0d d1=%0d d2=%0d last=%0d",
                   $time, event_kind_i, channel_i, first_data_i, second_data_i,
                   last_of_run_i);
          mismatch_count_o++;
        end else begin
          want = wanted_events.pop_front();
          if (got !== want) begin
            $display("%0t: event mismatch expected kind=%0d ch=%0d d1=%0d d2=%0d last=%0d",
                     $time, want.kind, want.channel, want.first_data, want.second_data,
                     want.last);
            $display("%0t:                  actual kind=%0d ch=%0d d1=%0d d2=%0d last=%0d",
                     $time, event_kind_i, channel_i, first_data_i, second_data_i,
                     last_of_run_i);
            mismatch_count_o++;
          end
        end
      end
      if (rx_valid_i && rx_ready_i) decode_midi_byte(rx_byte_i);
    end
    pending_events_o = wanted_events.size();
  end

endmodule

### dv/tb.sv
// Testbench top: drives MIDI bytes into the parser, paces the event sink and reports.
module tb import mbsp_pkg::*; ();

  localparam int unsigned ByteTarget  = 1850;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 20;

  logic       clk;
  logic       rst_n;
  logic       rx_valid;
  logic       rx_ready;
  logic [7:0] rx_byte;
  logic       ev_valid;
  logic       ev_ready;
  logic [2:0] event_kind;
  logic [3:0] channel;
  logic [6:0] first_data;
  logic [6:0] second_data;
  logic       last_of_run;

  int unsigned mismatch_count;
  int unsigned pending_events;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  bit          calm;
  bit          hold_req;
  logic [7:0]  last_status;

  // Edge cases: stray data, running status, velocity zero, every channel message,
  // real-time bytes, real-time inside exclusive, system common cancelling status
  logic [7:0] directed_bytes [34] = '{
    8'h40,
    8'h90, 8'h3C, 8'h7F, 8'h3C, 8'h00,
    8'h8F, 8'h7F, 8'h00,
    8'hA5, 8'h01, 8'h02,
    8'hB3, 8'h07, 8'h7F,
    8'hC9, 8'h00, 8'h7F,
    8'hD2, 8'h10,
    8'hE1, 8'h00, 8'h40,
    8'hFA, 8'hF8, 8'hFC, 8'hFE,
    8'hF0, 8'h90, 8'hF8, 8'hF7,
    8'h11, 8'hF3, 8'h05
  };

  midi_byte_stream_parser dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .rx_valid_i    (rx_valid),
    .rx_ready_o    (rx_ready),
    .rx_byte_i     (rx_byte),
    .ev_valid_o    (ev_valid),
    .ev_ready_i    (ev_ready),
    .event_kind_o  (event_kind),
    .channel_o     (channel),
    .first_data_o  (first_data),
    .second_data_o (second_data),
    .last_of_run_o (last_of_run)
  );

  mbsp_event_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .rx_valid_i       (rx_valid),
    .rx_ready_i       (rx_ready),
    .rx_byte_i        (rx_byte),
    .ev_valid_i       (ev_valid),
    .ev_ready_i       (ev_ready),
    .event_kind_i     (event_kind),
    .channel_i        (channel),
    .first_data_i     (first_data),
    .second_data_i    (second_data),
    .last_of_run_i    (last_of_run),
    .mismatch_count_o (mismatch_count),
    .pending_events_o (pending_events)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Event sink: random back-pressure, one long hold-off on request
  initial begin : ev_sink
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    ev_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        ev_ready = 1'b0;
        hold_left--;
      end else begin
        ev_ready = calm || ($urandom_range(99) >= 18);
      end
    end
  end

  // Offer one byte, with random idle cycles ahead of it unless calm, and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    if (!calm) begin
      while ($urandom_range(99) < 18) begin
        rx_valid = 1'b0;
        @(negedge clk);
      end
    end
    rx_valid = 1'b1;
    rx_byte  = b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_data();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'h7F;
    return 8'($urandom_range(127));
  endfunction

  // Channel message, often under running status, sometimes cut short or
  // with real-time bytes in between the data
  task automatic send_channel_message();
    logic [7:0] status;
    int         n_data;
    if (last_status[7] && $urandom_range(99) < 40) begin
      status = last_status;
    end else begin
      status = {NibNoteOff + 4'($urandom_range(6)), 4'($urandom_range(15))};
      send_byte(status);
      last_status = status;
    end
    n_data = (status[7:4] == NibProgram || status[7:4] == NibChanPres) ? 1 : 2;
    if ($urandom_range(99) < 6) n_data = n_data - 1;
    for (int i = 0; i < n_data; i++) begin
      if ($urandom_range(99) < 8) send_byte(ByteClock | 8'($urandom_range(7)));
      send_byte(pick_data());
    end
  endtask

  task automatic send_clock_run();
    int unsigned n;
    n = ($urandom_range(99) < 20) ? $urandom_range(20, 30) : $urandom_range(1, 3);
    repeat (n) send_byte(ByteClock);
  endtask

  task automatic send_sysex();
    send_byte(ByteSysExBeg);
    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
    if ($urandom_range(99) < 90) send_byte(ByteSysExEnd);
    last_status = '0;
  endtask

  // Stimulus
  initial begin
    int unsigned r;
    rst_n       = 1'b0;
    rx_valid    = 1'b0;
    rx_byte     = '0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    bytes_sent  = 0;
    last_status = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    while (bytes_sent < ByteTarget) begin
      calm = (bytes_sent >= 600) && (bytes_sent < 900);
      // fill the parser while the sink holds off
      if (!hold_req && bytes_sent >= 1200) begin
        hold_req = 1'b1;
        repeat (30) send_byte(($urandom_range(1) != 0) ? ByteStart : ByteClock);
      end
      r = $urandom_range(99);
      if (r < 60) begin
        send_channel_message();
      end else if (r < 75) begin
        send_clock_run();
      end else if (r < 79) begin
        send_byte(ByteStart);
      end else if (r < 82) begin
        send_byte(ByteStop);
      end else if (r < 85) begin
        send_byte(ByteClock | 8'($urandom_range(7)));
      end else if (r < 90) begin
        send_sysex();
      end else if (r < 94) begin
        send_byte({NibSystem, 4'($urandom_range(1, 6))});
        last_status = '0;
        repeat ($urandom_range(2)) send_byte(pick_data());
      end else begin
        send_byte(8'($urandom_range(255)));
        last_status = '0;
      end
    end

    @(negedge clk);
    rx_valid = 1'b0;
    while (pending_events != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/mbsp_pkg.sv
hw/rtl/mbsp_front.sv
hw/rtl/mbsp_queue.sv
hw/rtl/mbsp_back.sv
hw/rtl/midi_byte_stream_parser.sv
dv/mbsp_event_checker.sv
dv/tb.sv
